[rtl/chrg_pkg.sv]
package chrg_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 7;

  // longest run, longer counts saturate here
  localparam logic [CountW-1:0] MaxRun = CountW'(64);

  // round keys
  localparam logic [DataW-1:0] Round1K1 = 32'hbaa96887;
  localparam logic [DataW-1:0] Round1K2 = 32'h4b0f3b58;
  localparam logic [DataW-1:0] Round2K1 = 32'h1e17d32c;
  localparam logic [DataW-1:0] Round2K2 = 32'he874f0c3;

  // data that rides alongside the hash through the pipeline
  typedef struct packed {
    logic [DataW-1:0] ctr;
    logic [DataW-1:0] scale;
    logic             last;
  } chrg_side_t;

endpackage

[rtl/chrg_if.sv]
interface chrg_in_if
  import chrg_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [DataW-1:0]  counter_start;
  logic [CountW-1:0] count;
  logic [DataW-1:0]  scale;

  modport source (output valid, counter_start, count, scale, input ready);
  modport sink   (input valid, counter_start, count, scale, output ready);
endinterface

interface chrg_out_if
  import chrg_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] raw_value;
  logic [DataW-1:0] scaled_value;
  logic [DataW-1:0] counter_next;
  logic             last;

  modport source (output valid, raw_value, scaled_value, counter_next, last, input ready);
  modport sink   (input valid, raw_value, scaled_value, counter_next, last, output ready);
endinterface

interface chrg_cfg_if
  import chrg_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/chrg_seq.sv]
module chrg_seq
  import chrg_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DataW-1:0]  counter_start_i,
  input  logic [CountW-1:0] count_i,
  input  logic [DataW-1:0]  scale_i,
  output logic              vld_o,
  output chrg_side_t        side_o
);

  logic [DataW-1:0]  ctr_q, ctr_d;
  logic [DataW-1:0]  scale_q, scale_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic [CountW-1:0] cnt_sat;
  logic              load;

  // free once the last value of the run leaves
  assign in_ready_o = adv_i && (rem_q <= CountW'(1));
  assign load       = in_valid_i && in_ready_o;
  assign cnt_sat    = (count_i > MaxRun) ? MaxRun : count_i;

  assign vld_o        = (rem_q != '0);
  assign side_o.ctr   = ctr_q;
  assign side_o.scale = scale_q;
  assign side_o.last  = (rem_q == CountW'(1));

  always_comb begin
    ctr_d   = ctr_q;
    scale_d = scale_q;
    rem_d   = rem_q;
    if (load) begin
      ctr_d   = counter_start_i;
      scale_d = scale_i;
      rem_d   = cnt_sat;
    end else if (adv_i && vld_o) begin
      ctr_d = ctr_q + DataW'(1);
      rem_d = rem_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q   <= '0;
      scale_q <= '0;
      rem_q   <= '0;
    end else begin
      ctr_q   <= ctr_d;
      scale_q <= scale_d;
      rem_q   <= rem_d;
    end
  end

endmodule

[rtl/chrg_round.sv]
module chrg_round
  import chrg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  input  logic [DataW-1:0] k1_i,
  input  logic [DataW-1:0] k2_i,
  input  chrg_side_t       side_i,
  output logic             vld_o,
  output logic [DataW-1:0] res_o,
  output chrg_side_t       side_o
);

  logic [DataW-1:0] w;
  logic [15:0]      v_hi, w_lo;
  logic [DataW-1:0] diff;
  logic [16:0]      sum;
  logic [DataW-1:0] p_sq_d, p_wv_d;
  logic [DataW-1:0] p_sq_q, p_wv_q, b_q;
  chrg_side_t       side_a_q;
  logic             vld_a_q;
  logic [DataW-1:0] u, rot, res_d;
  logic             vld_b_q;
  logic [DataW-1:0] res_q;
  chrg_side_t       side_b_q;

  // stage a: the two products
  assign w      = a_i ^ k1_i;
  assign v_hi   = w[31:16];
  assign w_lo   = w[15:0];
  assign diff   = {16'b0, v_hi} - {16'b0, w_lo};
  assign sum    = {1'b0, v_hi} + {1'b0, w_lo};
  assign p_sq_d = diff * {15'b0, sum};
  assign p_wv_d = {16'b0, v_hi} * {16'b0, w_lo};

  // stage b: rotate, key and fold into b
  assign u     = ~p_sq_q;
  assign rot   = {u[15:0], u[31:16]};
  assign res_d = b_q ^ ((rot ^ k2_i) + p_wv_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (adv_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      p_sq_q   <= p_sq_d;
      p_wv_q   <= p_wv_d;
      b_q      <= b_i;
      side_a_q <= side_i;
      res_q    <= res_d;
      side_b_q <= side_a_q;
    end
  end

  assign vld_o  = vld_b_q;
  assign res_o  = res_q;
  assign side_o = side_b_q;

endmodule

[rtl/chrg_scale.sv]
module chrg_scale
  import chrg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             vld_i,
  input  logic [DataW-1:0] raw_i,
  input  chrg_side_t       side_i,
  output logic             vld_o,
  output logic [DataW-1:0] raw_o,
  output logic [DataW-1:0] scaled_o,
  output logic [DataW-1:0] ctr_next_o,
  output logic             last_o
);

  logic [2*DataW-1:0] prod;
  logic               vld_q;
  logic [DataW-1:0]   raw_q, scaled_q, ctr_next_q;
  logic               last_q;

  // 0.32 fraction times Q16.16, keep the upper word
  assign prod = {{DataW{1'b0}}, raw_i} * {{DataW{1'b0}}, side_i.scale};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      raw_q      <= raw_i;
      scaled_q   <= prod[2*DataW-1:DataW];
      ctr_next_q <= side_i.ctr + DataW'(1);
      last_q     <= side_i.last;
    end
  end

  assign vld_o      = vld_q;
  assign raw_o      = raw_q;
  assign scaled_o   = scaled_q;
  assign ctr_next_o = ctr_next_q;
  assign last_o     = last_q;

endmodule

[rtl/counter_hash_random_generator_core.sv]
// counter-based random generator: each input transaction opens a run of count
// values (1 to 64, larger counts saturate at 64, zero gives no output) starting
// at counter_start; every value is a two-round pseudo-DES hash of the counter
// and the low_index register, given raw (also an unsigned 0.32 fraction) and
// multiplied by the Q16.16 scale. the run sequencer issues one counter per
// cycle while the pipeline advances, and the next input transaction is taken
// in the cycle that issues the last value of the current run. an issued value
// passes the two registered stages of each round, then the scaling register,
// which is the output register. the whole pipeline advances together and holds
// while a result waits on a low output ready. low_index is written through the
// config channel, which is always ready, and should only change while no run is
// in flight.
module counter_hash_random_generator_core
  import chrg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  chrg_cfg_if.sink cfg_i,
  chrg_in_if.sink  in_i,
  chrg_out_if.source out_o
);

  logic             adv;
  logic [DataW-1:0] low_index_q;

  logic             seq_vld;
  chrg_side_t       seq_side;
  logic             r1_vld;
  logic [DataW-1:0] r1_res;
  chrg_side_t       r1_side;
  logic             r2_vld;
  logic [DataW-1:0] r2_res;
  chrg_side_t       r2_side;

  // pipeline moves when the output register is empty or being drained
  assign adv = !out_o.valid || out_o.ready;

  // stream key register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_index_q <= '0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      low_index_q <= cfg_i.data;
    end
  end

  // run sequencer: one counter per cycle while the pipeline advances
  chrg_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .adv_i           (adv),
    .in_valid_i      (in_i.valid),
    .in_ready_o      (in_i.ready),
    .counter_start_i (in_i.counter_start),
    .count_i         (in_i.count),
    .scale_i         (in_i.scale),
    .vld_o           (seq_vld),
    .side_o          (seq_side)
  );

  // first round mixes the counter into the key word
  chrg_round u_round1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (seq_vld),
    .a_i    (seq_side.ctr),
    .b_i    (low_index_q),
    .k1_i   (Round1K1),
    .k2_i   (Round1K2),
    .side_i (seq_side),
    .vld_o  (r1_vld),
    .res_o  (r1_res),
    .side_o (r1_side)
  );

  // second round mixes that result back into the counter
  chrg_round u_round2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (r1_vld),
    .a_i    (r1_res),
    .b_i    (r1_side.ctr),
    .k1_i   (Round2K1),
    .k2_i   (Round2K2),
    .side_i (r1_side),
    .vld_o  (r2_vld),
    .res_o  (r2_res),
    .side_o (r2_side)
  );

  // scaling multiply, doubles as the output register
  chrg_scale u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .vld_i      (r2_vld),
    .raw_i      (r2_res),
    .side_i     (r2_side),
    .vld_o      (out_o.valid),
    .raw_o      (out_o.raw_value),
    .scaled_o   (out_o.scaled_value),
    .ctr_next_o (out_o.counter_next),
    .last_o     (out_o.last)
  );

endmodule

[rtl/chrg_checker.sv]
module chrg_checker
  import chrg_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             cfg_valid_i,
  input logic             cfg_ready_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [DataW-1:0] out_raw_i,
  input logic [DataW-1:0] out_scaled_i,
  input logic [DataW-1:0] out_next_i,
  input logic             out_last_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_raw_i)
      && $stable(out_scaled_i) && $stable(out_next_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // a stalled output freezes the pipeline, so no new run is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  // key register never back-pressures
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_i)
    else $error("config write refused");

  // reset empties the pipeline
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind counter_hash_random_generator_core chrg_checker u_chrg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_valid_i  (cfg_i.valid),
  .cfg_ready_i  (cfg_i.ready),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_raw_i    (out_o.raw_value),
  .out_scaled_i (out_o.scaled_value),
  .out_next_i   (out_o.counter_next),
  .out_last_i   (out_o.last)
);

[tb/tb_top.sv]
module tb_top;
  import chrg_pkg::*;

  // one run request as it crosses the input channel
  typedef struct packed {
    logic [DataW-1:0]  counter_start;
    logic [CountW-1:0] count;
    logic [DataW-1:0]  scale;
  } run_req_t;

  // one generated value as it leaves the output channel
  typedef struct packed {
    logic [DataW-1:0] raw_value;
    logic [DataW-1:0] scaled_value;
    logic [DataW-1:0] counter_next;
    logic             last;
  } sample_t;

  // cycles from the last issued value to an empty pipeline, with margin
  localparam int unsigned DrainCycles = 16;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // clock with a period of 4
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  chrg_cfg_if cfg_bus ();
  chrg_in_if  in_bus ();
  chrg_out_if out_bus ();

  counter_hash_random_generator_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus.sink),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  // testbench side registers, all known from time zero
  logic             cfg_valid = 1'b0;
  logic [DataW-1:0] cfg_data  = '0;
  logic             in_valid  = 1'b0;
  run_req_t         cur_run   = '0;
  logic             out_ready = 1'b0;

  assign cfg_bus.valid        = cfg_valid;
  assign cfg_bus.data         = cfg_data;
  assign in_bus.valid         = in_valid;
  assign in_bus.counter_start = cur_run.counter_start;
  assign in_bus.count         = cur_run.count;
  assign in_bus.scale         = cur_run.scale;
  assign out_bus.ready        = out_ready;

  // run requests waiting to be offered, and values still owed by the block
  run_req_t pending_runs[$];
  sample_t  owed_samples[$];

  // our own copy of the stream key register
  logic [DataW-1:0] stream_key = '0;

  // idling knobs in percent, changed only between phases
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned fail_count      = 0;
  int unsigned runs_accepted   = 0;
  int unsigned samples_checked = 0;
  int unsigned key_writes      = 0;

  // one pseudo-des style round, everything modulo 2^32
  function automatic logic [DataW-1:0] mix_step(input logic [DataW-1:0] a, b, k1, k2);
    logic [DataW-1:0] w, v, u, rot;
    w   = a ^ k1;
    v   = {16'h0, w[31:16]};
    w   = {16'h0, w[15:0]};
    u   = ~((v - w) * (v + w));
    rot = {u[15:0], u[31:16]};
    return b ^ ((rot ^ k2) + w * v);
  endfunction

  // two rounds: counter against key, then the mixed word against the counter
  function automatic logic [DataW-1:0] counter_hash(input logic [DataW-1:0] ctr, key);
    logic [DataW-1:0] m;
    m = mix_step(ctr, key, Round1K1, Round1K2);
    return mix_step(m, ctr, Round2K1, Round2K2);
  endfunction

  // expand one accepted request into the values the block owes for it
  task automatic queue_run_samples(input run_req_t req);
    logic [DataW-1:0]  ctr;
    logic [CountW-1:0] n;
    logic [2*DataW-1:0] prod;
    sample_t           s;
    int                i;
    ctr = req.counter_start;
    // counts above the longest run saturate, zero gives nothing
    n = (req.count > MaxRun) ? MaxRun : req.count;
    for (i = 0; i < n; i++) begin
      s.raw_value    = counter_hash(ctr, stream_key);
      prod           = {32'h0, s.raw_value} * {32'h0, req.scale};
      s.scaled_value = prod[2*DataW-1:DataW];
      ctr            = ctr + 1'b1;
      s.counter_next = ctr;
      s.last         = (i == n - 1);
      owed_samples.push_back(s);
    end
  endtask

  // driver: takes requests from the pending queue and holds each until taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_bus.ready) begin
        queue_run_samples(cur_run);
        runs_accepted++;
      end
      if (!in_valid || in_bus.ready) begin
        if (pending_runs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_run  <= pending_runs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares each output transaction with the oldest owed value
  always @(posedge clk) begin
    sample_t want;
    if (rst_n) begin
      if (out_bus.valid && out_ready) begin
        if (owed_samples.size() == 0) begin
          $error("output transaction with nothing owed: raw_value %h", out_bus.raw_value);
          fail_count++;
        end else begin
          want = owed_samples.pop_front();
          samples_checked++;
          if (out_bus.raw_value !== want.raw_value) begin
            $error("raw_value: expected %h, actual %h", want.raw_value, out_bus.raw_value);
            fail_count++;
          end
          if (out_bus.scaled_value !== want.scaled_value) begin
            $error("scaled_value: expected %h, actual %h", want.scaled_value,
                   out_bus.scaled_value);
            fail_count++;
          end
          if (out_bus.counter_next !== want.counter_next) begin
            $error("counter_next: expected %h, actual %h", want.counter_next,
                   out_bus.counter_next);
            fail_count++;
          end
          if (out_bus.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_bus.last);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // random request: mostly short runs, some long, some saturating, a few empty
  function automatic run_req_t random_run();
    run_req_t    r;
    int unsigned pick;
    int unsigned sel;
    pick = $urandom_range(99);
    sel  = $urandom_range(9);
    r.counter_start = $urandom;
    // now and then start close to the counter wrap
    if ($urandom_range(9) == 0) r.counter_start = 32'hffffffff - $urandom_range(8);
    if (pick < 5)       r.count = '0;
    else if (pick < 10) r.count = CountW'($urandom_range(127, 65));
    else if (pick < 22) r.count = CountW'($urandom_range(64, 9));
    else                r.count = CountW'($urandom_range(8, 1));
    case (sel)
      0:       r.scale = '0;
      1:       r.scale = 32'hffffffff;
      2:       r.scale = 32'h0001_0000;
      default: r.scale = $urandom;
    endcase
    return r;
  endfunction

  // wait, settled at the falling edge, until nothing is queued, offered or owed
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_runs.size() != 0 || in_valid || owed_samples.size() != 0);
  endtask

  // a zero count run owes nothing and issues no value into the pipeline
  task automatic wait_drained();
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
  endtask

  // key write transaction, only ever issued while the block is drained
  task automatic write_stream_key(input logic [DataW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_bus.ready);
    stream_key = value;
    key_writes++;
    cfg_valid <= 1'b0;
  endtask

  // one random phase, optionally with the sender holding off halfway
  task automatic random_phase(input int unsigned n_items, input int unsigned send_pct,
                              input int unsigned recv_pct, input bit hold_midway);
    int unsigned i;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (i = 0; i < n_items; i++) begin
      pending_runs.push_back(random_run());
      // sender stops until every owed value has arrived
      if (hold_midway && i == n_items / 2) wait_idle();
    end
    wait_drained();
  endtask

  initial begin
    // reset held, then released at a falling edge, away from the rising edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part under the reset key: field extremes, counter wrap,
    // saturating counts, zero counts and unity or full scale
    pending_runs.push_back('{32'h0000_0000, 7'd1,   32'h0000_0000});
    pending_runs.push_back('{32'hffff_ffff, 7'd3,   32'h0001_0000});
    pending_runs.push_back('{32'hffff_fffe, 7'd2,   32'hffff_ffff});
    pending_runs.push_back('{32'h1357_9bdf, 7'd64,  32'h8000_0000});
    pending_runs.push_back('{32'h2468_ace0, 7'd65,  32'h0001_0000});
    pending_runs.push_back('{32'hffff_ffc0, 7'd127, 32'hffff_ffff});
    pending_runs.push_back('{32'h0bad_cafe, 7'd0,   32'h1234_5678});
    pending_runs.push_back('{32'h7fff_ffff, 7'd1,   32'hffff_ffff});
    pending_runs.push_back('{32'h8000_0000, 7'd2,   32'h0000_0001});
    pending_runs.push_back('{32'h5555_5555, 7'd42,  32'haaaa_aaaa});
    pending_runs.push_back('{32'haaaa_aaaa, 7'd85,  32'h5555_5555});
    pending_runs.push_back('{32'hffff_ffff, 7'd1,   32'hffff_ffff});
    pending_runs.push_back('{32'h0000_0000, 7'd0,   32'h0000_0000});
    pending_runs.push_back('{32'h1234_5678, 7'd5,   32'h0001_8000});
    pending_runs.push_back('{32'hdead_beef, 7'd16,  32'h0000_ffff});
    wait_drained();

    // key at its all-ones extreme, no idling at all
    write_stream_key(32'hffff_ffff);
    random_phase(65, 0, 0, 1'b0);

    // random key, sparse sender with a full hold-off halfway
    write_stream_key($urandom);
    random_phase(65, 82, 0, 1'b1);

    // key back to zero, receiver stalling most of the time
    write_stream_key(32'h0000_0000);
    random_phase(65, 0, 82, 1'b0);

    // single top bit key, light idling on both sides
    write_stream_key(32'h8000_0000);
    random_phase(65, 11, 11, 1'b0);

    $display("covered %0d run requests, %0d checked values, %0d key writes",
             runs_accepted, samples_checked, key_writes);
    $display("idling phases: none, sparse sender, stalling receiver, light on both");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
